// ===== src/sorted_byte_statistics_defines.svh =====
// Assertion macros for the sorted byte statistics block.
`ifndef SORTED_BYTE_STATISTICS_DEFINES_SVH
`define SORTED_BYTE_STATISTICS_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SBS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbs assertion failed (same-cycle implication)");

// next-cycle implication
`define SBS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbs assertion failed (next-cycle implication)");

`else

`define SBS_ASSERT_IMP(label, clk, rst, ante, cons)
`define SBS_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/sbs_pkg.sv =====
// Shared types and constants for the sorted byte statistics block.
`timescale 1ns / 1ps

package sbs_pkg;

   localparam int MAX_SAMPLES_DEFAULT = 64;
   localparam int DATA_W              = 8;

   typedef struct packed {
      logic [DATA_W-1:0] sample;
      logic              is_last;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] maximum;
      logic [DATA_W-1:0] minimum;
      logic [DATA_W-1:0] median;
      logic [DATA_W-1:0] mean;
      logic              overflow;
   } rsp_type;

endpackage

// ===== src/sorted_byte_statistics.sv =====
// Sorted byte statistics: insertion-sorted sample store, max/min/median/mean per set.
// A sample is stored in ST_IDLE when the store is empty, or dropped there when full; else
//   ST_RD and ST_CMP compare/shift one store entry at a time, ST_PUT when index 0 is reached.
// A last sample then passes ST_F0 to ST_F4, the bit-serial divider ST_DIV and result state ST_OUT.
// Reset (synchronous): count, sum, overflow flag and sequencer clear; no clearing pass.
`timescale 1ns / 1ps
`include "sorted_byte_statistics_defines.svh"

module sorted_byte_statistics
   import sbs_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CW    = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = $clog2(255 * MAX_SAMPLES + 1);
   localparam int STW   = $clog2(SUM_W + 1);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RD   = 4'd1;
   localparam logic [3:0] ST_CMP  = 4'd2;
   localparam logic [3:0] ST_PUT  = 4'd3;
   localparam logic [3:0] ST_F0   = 4'd4;
   localparam logic [3:0] ST_F1   = 4'd5;
   localparam logic [3:0] ST_F2   = 4'd6;
   localparam logic [3:0] ST_F3   = 4'd7;
   localparam logic [3:0] ST_F4   = 4'd8;
   localparam logic [3:0] ST_DIV  = 4'd9;
   localparam logic [3:0] ST_OUT  = 4'd10;

   logic [DATA_W-1:0] mem [MAX_SAMPLES];

   logic [3:0]        state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              drop_ff, drop_in;
   logic [AW-1:0]     k_ff, k_in;
   logic [DATA_W-1:0] v_ff, v_in;
   logic              last_ff, last_in;
   logic [DATA_W-1:0] max_ff, max_in;
   logic [DATA_W-1:0] min_ff, min_in;
   logic [DATA_W-1:0] mid_ff, mid_in;
   logic [DATA_W-1:0] med_ff, med_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic [STW-1:0]    step_ff, step_in;
   logic [DATA_W-1:0] rd_ff;

   logic              we;
   logic [AW-1:0]     wa;
   logic [DATA_W-1:0] wd;
   logic [AW-1:0]     ra;
   logic [CW:0]       trial;
   logic [CW:0]       trial_sub;
   logic              qbit;
   logic [DATA_W:0]   mid_sum;

   // divider step: shift in the next dividend bit, subtract if it fits
   assign trial     = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_sub = trial - {1'b0, cnt_ff};
   assign qbit      = (trial >= {1'b0, cnt_ff});
   assign mid_sum   = {1'b0, mid_ff} + {1'b0, rd_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      drop_in  = drop_ff;
      k_in     = k_ff;
      v_in     = v_ff;
      last_in  = last_ff;
      max_in   = max_ff;
      min_in   = min_ff;
      mid_in   = mid_ff;
      med_in   = med_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      we       = 1'b0;
      wa       = k_ff;
      wd       = v_ff;
      ra       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               v_in    = req_data.sample;
               last_in = req_data.is_last;
               if (cnt_ff < CW'(MAX_SAMPLES)) begin
                  sum_in = sum_ff + SUM_W'(req_data.sample);
                  cnt_in = cnt_ff + 1'b1;
                  k_in   = AW'(cnt_ff);
                  if (cnt_ff == '0) begin
                     we       = 1'b1;
                     wa       = '0;
                     wd       = req_data.sample;
                     state_in = req_data.is_last ? ST_F0 : ST_IDLE;
                  end else begin
                     state_in = ST_RD;
                  end
               end else begin
                  drop_in  = 1'b1;
                  state_in = req_data.is_last ? ST_F0 : ST_IDLE;
               end
            end
         end
         ST_RD: begin
            ra       = k_ff - 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            we = 1'b1;
            if (rd_ff < v_ff) begin
               // smaller entry moves one place down
               wd       = rd_ff;
               k_in     = k_ff - 1'b1;
               state_in = (k_ff == AW'(1)) ? ST_PUT : ST_RD;
            end else begin
               state_in = last_ff ? ST_F0 : ST_IDLE;
            end
         end
         ST_PUT: begin
            we       = 1'b1;
            state_in = last_ff ? ST_F0 : ST_IDLE;
         end
         ST_F0: begin
            ra       = '0;
            state_in = ST_F1;
         end
         ST_F1: begin
            ra       = AW'(cnt_ff - 1'b1);
            max_in   = rd_ff;
            state_in = ST_F2;
         end
         ST_F2: begin
            ra       = AW'(cnt_ff >> 1);
            min_in   = rd_ff;
            state_in = ST_F3;
         end
         ST_F3: begin
            ra       = AW'((cnt_ff >> 1) - 1'b1);
            mid_in   = rd_ff;
            state_in = ST_F4;
         end
         ST_F4: begin
            med_in   = cnt_ff[0] ? mid_ff : mid_sum[DATA_W:1];
            quo_in   = sum_ff;
            rem_in   = '0;
            step_in  = STW'(SUM_W);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in   = qbit ? trial_sub[CW-1:0] : trial[CW-1:0];
            quo_in   = {quo_ff[SUM_W-2:0], qbit};
            step_in  = step_ff - 1'b1;
            state_in = (step_ff == STW'(1)) ? ST_OUT : ST_DIV;
         end
         ST_OUT: begin
            cnt_in   = '0;
            sum_in   = '0;
            drop_in  = 1'b0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      v_ff    <= v_in;
      last_ff <= last_in;
      max_ff  <= max_in;
      min_ff  <= min_in;
      mid_ff  <= mid_in;
      med_ff  <= med_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[ra];
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = (state_ff == ST_OUT);
   assign rsp_data.maximum   = max_ff;
   assign rsp_data.minimum   = min_ff;
   assign rsp_data.median    = med_ff;
   assign rsp_data.mean      = quo_ff[DATA_W-1:0];
   assign rsp_data.overflow  = drop_ff;

   `SBS_ASSERT_NXT(a_one_rsp_per_set, clock, reset, rsp_valid, !rsp_valid && !busy)
   `SBS_ASSERT_NXT(a_clear_after_rsp, clock, reset, rsp_valid, cnt_ff == '0 && sum_ff == '0)
   `SBS_ASSERT_IMP(a_cnt_in_range, clock, reset, 1'b1, cnt_ff <= CW'(MAX_SAMPLES))
   `SBS_ASSERT_IMP(a_div_rem_below, clock, reset, state_ff == ST_DIV, rem_ff < cnt_ff)

endmodule
